[hdl/lcd_window_write_formatter_top_assert.svh]
// assertion macros used by the checker file
`ifndef LCD_WINDOW_WRITE_FORMATTER_TOP_ASSERT_SVH
`define LCD_WINDOW_WRITE_FORMATTER_TOP_ASSERT_SVH

// implication checked outside reset, consequent in the next cycle
`define LWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcd window write formatter assertion failed");

// implication that also holds across reset, consequent in the next cycle
`define LWF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lcd window write formatter reset assertion failed");

`endif

[hdl/lwf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_pkg
// Types and constants of the display window write formatter.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // input mode codes
    localparam logic [1:0] MODE_WINDOW = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_COLUMN_OPCODE = 3'd2;
    localparam logic [2:0] CFG_ROW_OPCODE    = 3'd3;
    localparam logic [2:0] CFG_MEMWR_OPCODE  = 3'd4;

    // reset values of the configuration registers
    localparam logic [14:0] SCREEN_WIDTH_RST  = 15'd128;
    localparam logic [14:0] SCREEN_HEIGHT_RST = 15'd160;
    localparam logic [7:0]  COLUMN_OPCODE_RST = 8'd42;
    localparam logic [7:0]  ROW_OPCODE_RST    = 8'd43;
    localparam logic [7:0]  MEMWR_OPCODE_RST  = 8'd44;

    // one classified request waiting to be serialized
    typedef struct packed {
        logic        has_window;
        logic        has_color;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_last;
        logic [15:0] y_last;
        logic [15:0] color;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [7:0] column_opcode;
        logic [7:0] row_opcode;
        logic [7:0] memwr_opcode;
    } opcodes_t;

endpackage

[hdl/lwf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_front
// Accepts drawing requests, clips pixels and pushes descriptors to the queue.
// ----------------------------------------------------------------------------
module lwf_front (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic signed [15:0]      s_x_start,
    input  logic signed [15:0]      s_y_start,
    input  logic [15:0]             s_x_stop,
    input  logic [15:0]             s_y_stop,
    input  logic [15:0]             s_pixel_color,
    input  logic [14:0]             screen_width,
    input  logic [14:0]             screen_height,
    input  lwf_pkg::q_status_t      q_status,
    output logic                    push,
    output lwf_pkg::desc_t          push_data
);
    import lwf_pkg::*;

    logic [15:0] xs;
    logic [15:0] ys;
    logic        on_screen;
    logic        keep;

    assign xs = $unsigned(s_x_start);
    assign ys = $unsigned(s_y_start);

    // negative coordinates have bit 15 set and are off screen
    assign on_screen = !xs[15] && !ys[15]
                     && (xs[14:0] < screen_width) && (ys[14:0] < screen_height);

    assign keep = (s_mode == MODE_WINDOW) || (s_mode == MODE_COLOR)
               || ((s_mode == MODE_PIXEL) && on_screen);

    assign s_ready = !q_status.full;
    // dropped transactions are accepted but push nothing
    assign push    = s_valid && s_ready && keep;

    always_comb begin
        push_data.has_window = (s_mode != MODE_COLOR);
        push_data.has_color  = (s_mode != MODE_WINDOW);
        push_data.x_start    = xs;
        push_data.y_start    = ys;
        push_data.color      = s_pixel_color;
        if (s_mode == MODE_PIXEL) begin
            push_data.x_last = xs;
            push_data.y_last = ys;
        end else begin
            push_data.x_last = s_x_stop - 16'd1;
            push_data.y_last = s_y_stop - 16'd1;
        end
    end

endmodule

[hdl/lwf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_queue
// Small descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module lwf_queue #(
    parameter int DEPTH = lwf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lwf_pkg::desc_t      push_data,
    input  logic                pop,
    output lwf_pkg::desc_t      pop_data,
    output lwf_pkg::q_status_t  q_status
);
    import lwf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.valid;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/lwf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_back
// Serializes one descriptor into command and data bytes, one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module lwf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lwf_pkg::q_status_t  q_status,
    input  lwf_pkg::desc_t      pop_data,
    output logic                pop,
    input  lwf_pkg::opcodes_t   opcodes,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_is_command,
    output logic                m_last_byte
);
    import lwf_pkg::*;

    // byte slots of the full pixel sequence
    localparam logic [3:0] SLOT_COL_CMD  = 4'd0;
    localparam logic [3:0] SLOT_XS_HI    = 4'd1;
    localparam logic [3:0] SLOT_XS_LO    = 4'd2;
    localparam logic [3:0] SLOT_XL_HI    = 4'd3;
    localparam logic [3:0] SLOT_XL_LO    = 4'd4;
    localparam logic [3:0] SLOT_ROW_CMD  = 4'd5;
    localparam logic [3:0] SLOT_YS_HI    = 4'd6;
    localparam logic [3:0] SLOT_YS_LO    = 4'd7;
    localparam logic [3:0] SLOT_YL_HI    = 4'd8;
    localparam logic [3:0] SLOT_YL_LO    = 4'd9;
    localparam logic [3:0] SLOT_MEMWR    = 4'd10;
    localparam logic [3:0] SLOT_COLOR_HI = 4'd11;
    localparam logic [3:0] SLOT_COLOR_LO = 4'd12;

    desc_t       cur_reg, cur_next;
    logic        active_reg, active_next;
    logic [3:0]  slot_reg, slot_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        cmd_reg, cmd_next;
    logic        last_reg, last_next;

    logic        out_load;
    logic        emit;
    logic [3:0]  end_slot;
    logic        at_end;
    logic [7:0]  slot_byte;
    logic        slot_cmd;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = active_reg && out_load;
    assign end_slot = cur_reg.has_color ? SLOT_COLOR_LO : SLOT_MEMWR;
    assign at_end   = (slot_reg == end_slot);
    // refill on the last byte so the next transaction follows without a gap
    assign pop      = q_status.valid && (!active_reg || (emit && at_end));

    always_comb begin
        slot_cmd = 1'b0;
        unique case (slot_reg)
            SLOT_COL_CMD: begin
                slot_byte = opcodes.column_opcode;
                slot_cmd  = 1'b1;
            end
            SLOT_XS_HI:    slot_byte = cur_reg.x_start[15:8];
            SLOT_XS_LO:    slot_byte = cur_reg.x_start[7:0];
            SLOT_XL_HI:    slot_byte = cur_reg.x_last[15:8];
            SLOT_XL_LO:    slot_byte = cur_reg.x_last[7:0];
            SLOT_ROW_CMD: begin
                slot_byte = opcodes.row_opcode;
                slot_cmd  = 1'b1;
            end
            SLOT_YS_HI:    slot_byte = cur_reg.y_start[15:8];
            SLOT_YS_LO:    slot_byte = cur_reg.y_start[7:0];
            SLOT_YL_HI:    slot_byte = cur_reg.y_last[15:8];
            SLOT_YL_LO:    slot_byte = cur_reg.y_last[7:0];
            SLOT_MEMWR: begin
                slot_byte = opcodes.memwr_opcode;
                slot_cmd  = 1'b1;
            end
            SLOT_COLOR_HI: slot_byte = cur_reg.color[15:8];
            SLOT_COLOR_LO: slot_byte = cur_reg.color[7:0];
            default:       slot_byte = 8'd0;
        endcase
    end

    always_comb begin
        cur_next     = cur_reg;
        active_next  = active_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        cmd_next     = cmd_reg;
        last_next    = last_reg;

        if (out_load) begin
            m_valid_next = active_reg;
        end
        if (emit) begin
            byte_next = slot_byte;
            cmd_next  = slot_cmd;
            last_next = at_end;
        end

        if (pop) begin
            cur_next    = pop_data;
            active_next = 1'b1;
            slot_next   = pop_data.has_window ? SLOT_COL_CMD : SLOT_COLOR_HI;
        end else if (emit) begin
            if (at_end) begin
                active_next = 1'b0;
            end else begin
                slot_next = slot_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            slot_reg    <= SLOT_COL_CMD;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
        last_reg <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_is_command = cmd_reg;
    assign m_last_byte  = last_reg;

endmodule

[hdl/lcd_window_write_formatter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_window_write_formatter_top
// Formats window, color and pixel requests into display controller bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one drawing request per transaction: mode 0 opens a
//   window (11 bytes), mode 1 sends a color (2 bytes), mode 2 draws a clipped
//   pixel (13 bytes, or none off screen). Mode 3 is accepted and dropped.
//   m_* channel gives one byte per transaction with its command flag and a
//   flag on the last byte of each request.
//   cfg_we/cfg_index/cfg_wdata write the screen size and the three opcodes;
//   write them only while no request is in flight.
//   Path: an accepted request goes through the queue and the byte sequencer
//   into the output byte register. Throughput: one output byte per cycle
//   while the receiver is ready, set by the byte sequencer. A queue of
//   QUEUE_DEPTH requests lets the input keep accepting while bytes drain.
//   Reset: config registers return to their defaults, queue and output empty.
//   When the receiver stalls the output byte holds, the queue fills and
//   s_ready drops once it is full.
// ----------------------------------------------------------------------------
module lcd_window_write_formatter_top #(
    parameter int QUEUE_DEPTH = lwf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [14:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic signed [15:0]  s_x_start,
    input  logic signed [15:0]  s_y_start,
    input  logic [15:0]         s_x_stop,
    input  logic [15:0]         s_y_stop,
    input  logic [15:0]         s_pixel_color,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_is_command,
    output logic                m_last_byte
);
    import lwf_pkg::*;

    logic [14:0] screen_width_reg;
    logic [14:0] screen_height_reg;
    opcodes_t    opcodes_reg;

    q_status_t   q_status;
    logic        push;
    desc_t       push_data;
    logic        pop;
    desc_t       pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg          <= SCREEN_WIDTH_RST;
            screen_height_reg         <= SCREEN_HEIGHT_RST;
            opcodes_reg.column_opcode <= COLUMN_OPCODE_RST;
            opcodes_reg.row_opcode    <= ROW_OPCODE_RST;
            opcodes_reg.memwr_opcode  <= MEMWR_OPCODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg          <= cfg_wdata;
                CFG_SCREEN_HEIGHT: screen_height_reg         <= cfg_wdata;
                CFG_COLUMN_OPCODE: opcodes_reg.column_opcode <= cfg_wdata[7:0];
                CFG_ROW_OPCODE:    opcodes_reg.row_opcode    <= cfg_wdata[7:0];
                CFG_MEMWR_OPCODE:  opcodes_reg.memwr_opcode  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    lwf_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_x_start     (s_x_start),
        .s_y_start     (s_y_start),
        .s_x_stop      (s_x_stop),
        .s_y_stop      (s_y_stop),
        .s_pixel_color (s_pixel_color),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    lwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    lwf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .opcodes      (opcodes_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_command (m_is_command),
        .m_last_byte  (m_last_byte)
    );

endmodule

[hdl/lwf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_checker
// Port level checks of the display window write formatter.
// ----------------------------------------------------------------------------
`include "lcd_window_write_formatter_top_assert.svh"

module lwf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_is_command,
    input logic        m_last_byte
);

    // output transaction holds while stalled
    `LWF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_is_command) && $stable(m_last_byte))

    // bytes of one request come back to back
    `LWF_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_last_byte, m_valid)

    // reset empties the output and the queue
    `LWF_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn, !m_valid)
    `LWF_ASSERT_ALWAYS(a_rst_ready, aclk, !aresetn, s_ready)

endmodule

bind lcd_window_write_formatter_top lwf_checker u_lwf_checker (.*);
